/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the encoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/wcu8_pkg.sv */
// ----------------------------------------------------------------------------
// wcu8_pkg
// Types and constants shared by the wide character to UTF-8 encoder.
// ----------------------------------------------------------------------------
package wcu8_pkg;

    localparam int unsigned MaxBytes = 4;

    localparam logic [31:0] Lim1Byte   = 32'h0000_007F;
    localparam logic [31:0] Lim2Byte   = 32'h0000_07FF;
    localparam logic [31:0] LimLowBmp  = 32'h0000_D7FF;
    localparam logic [31:0] HighSurLo  = 32'h0000_D800;
    localparam logic [31:0] HighSurHi  = 32'h0000_DBFF;
    localparam logic [31:0] LowSurLo   = 32'h0000_DC00;
    localparam logic [31:0] LowSurHi   = 32'h0000_DFFF;
    localparam logic [31:0] HighBmpLo  = 32'h0000_E000;
    localparam logic [31:0] LimBmp     = 32'h0000_FFFF;
    localparam logic [31:0] LimUnicode = 32'h0010_FFFF;

    localparam logic [7:0] Lead2 = 8'b1100_0000;
    localparam logic [7:0] Lead3 = 8'b1110_0000;
    localparam logic [7:0] Lead4 = 8'b1111_0000;
    localparam logic [7:0] Cont  = 8'b1000_0000;

    // One encoded request as it travels from the front end to the serializer.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [1:0]               last_idx;
        logic                     err;
    } t_rec;

    // Status of the request queue as seen by the front end and serializer.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

/* rtl/core/wide_char_to_utf8_encoder.sv */
// ----------------------------------------------------------------------------
// wide_char_to_utf8_encoder
// Encodes wide code units, UTF-16 surrogate halves included, into UTF-8 bytes.
//
//   Channel  Handshake                 Payload
//   input    i_in_valid / o_in_stall   i_code_unit[31:0]
//   output   o_out_valid / i_out_stall o_out_byte[7:0], o_last_of_run,
//                                      o_encode_error
//   config   i_cfg_we                  i_cfg_wdata
//
// The output sends one byte per cycle while i_out_stall is low; a request
// yields one to four bytes, and the serializer sets that rate.
// A request is held in the queue and then in the serializer's record before
// its first byte is valid on the output.
// The input takes a request every cycle while the queue has room.
// Synchronous active-low reset empties the queue, clears the surrogate state
// and sets direct supplementary encoding on.
// ----------------------------------------------------------------------------
module wide_char_to_utf8_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_code_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_encode_error
);

    wcu8_pkg::t_q_status q_status;
    wcu8_pkg::t_rec      push_rec;
    wcu8_pkg::t_rec      head_rec;
    logic                push;
    logic                pop;

    wcu8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_code_unit (i_code_unit),
        .i_q_status  (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    wcu8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_status   (q_status),
        .o_head     (head_rec)
    );

    wcu8_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_status     (q_status),
        .i_head         (head_rec),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_encode_error (o_encode_error)
    );

endmodule

/* rtl/core/wcu8_front.sv */
// ----------------------------------------------------------------------------
// wcu8_front
// Accepts code units, classifies them, tracks the surrogate state and builds
// the complete byte record for each request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcu8_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic [31:0]         i_code_unit,
    input  wcu8_pkg::t_q_status i_q_status,
    output logic                o_in_stall,
    output logic                o_push,
    output wcu8_pkg::t_rec      o_rec
);

    logic       r_direct_en;
    logic       r_pending;
    logic [1:0] r_bits;
    logic       n_pending;
    logic [1:0] n_bits;
    logic       accept;
    logic [4:0] plane;
    logic [31:0] v;

    assign v          = i_code_unit;
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept;
    assign plane      = {1'b0, v[9:6]} + 5'd1;

    always_comb begin
        o_rec     = '0;
        n_pending = 1'b0;
        n_bits    = 2'b00;
        if (v <= wcu8_pkg::Lim1Byte) begin
            o_rec.bytes[0] = v[7:0];
            o_rec.last_idx = 2'd0;
        end else if (v <= wcu8_pkg::Lim2Byte) begin
            o_rec.bytes[0] = wcu8_pkg::Lead2 | {3'b000, v[10:6]};
            o_rec.bytes[1] = wcu8_pkg::Cont | {2'b00, v[5:0]};
            o_rec.last_idx = 2'd1;
        end else if (v <= wcu8_pkg::LimLowBmp
                     || (v >= wcu8_pkg::HighBmpLo && v <= wcu8_pkg::LimBmp)) begin
            o_rec.bytes[0] = wcu8_pkg::Lead3 | {4'b0000, v[15:12]};
            o_rec.bytes[1] = wcu8_pkg::Cont | {2'b00, v[11:6]};
            o_rec.bytes[2] = wcu8_pkg::Cont | {2'b00, v[5:0]};
            o_rec.last_idx = 2'd2;
        end else if (v >= wcu8_pkg::HighSurLo && v <= wcu8_pkg::HighSurHi) begin
            // The plane is the high surrogate's top four payload bits plus one.
            o_rec.bytes[0] = wcu8_pkg::Lead4 | {5'b00000, plane[4:2]};
            o_rec.bytes[1] = wcu8_pkg::Cont | {2'b00, plane[1:0], v[5:2]};
            o_rec.last_idx = 2'd1;
            n_pending      = 1'b1;
            n_bits         = v[1:0];
        end else if (v >= wcu8_pkg::LowSurLo && v <= wcu8_pkg::LowSurHi) begin
            if (!r_pending) begin
                // An isolated low half reports an error and keeps the state.
                o_rec.err = 1'b1;
                n_pending = r_pending;
                n_bits    = r_bits;
            end else begin
                o_rec.bytes[0] = wcu8_pkg::Cont | {2'b00, r_bits, v[9:6]};
                o_rec.bytes[1] = wcu8_pkg::Cont | {2'b00, v[5:0]};
                o_rec.last_idx = 2'd1;
            end
        end else if (r_direct_en && v <= wcu8_pkg::LimUnicode) begin
            o_rec.bytes[0] = wcu8_pkg::Lead4 | {5'b00000, v[20:18]};
            o_rec.bytes[1] = wcu8_pkg::Cont | {2'b00, v[17:12]};
            o_rec.bytes[2] = wcu8_pkg::Cont | {2'b00, v[11:6]};
            o_rec.bytes[3] = wcu8_pkg::Cont | {2'b00, v[5:0]};
            o_rec.last_idx = 2'd3;
        end else begin
            o_rec.err = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct_en <= 1'b1;
            r_pending   <= 1'b0;
            r_bits      <= 2'b00;
        end else begin
            if (i_cfg_we) begin
                r_direct_en <= i_cfg_wdata;
            end
            if (accept) begin
                r_pending <= n_pending;
                r_bits    <= n_bits;
            end
        end
    end

    `ASSERT_CLK(a_high_sets_pending, i_clk, i_rst_n,
        accept && i_code_unit >= wcu8_pkg::HighSurLo && i_code_unit <= wcu8_pkg::HighSurHi
        |=> r_pending && r_bits == $past(i_code_unit[1:0]),
        "high surrogate did not leave pending state")
    `ASSERT_CLK(a_error_single, i_clk, i_rst_n,
        o_push && o_rec.err |-> o_rec.last_idx == 2'd0 && o_rec.bytes == '0,
        "error record is not a single zero byte")

endmodule

/* rtl/core/wcu8_fifo.sv */
// ----------------------------------------------------------------------------
// wcu8_fifo
// Short request queue between the front end and the byte serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcu8_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wcu8_pkg::t_rec      i_push_rec,
    input  logic                i_pop,
    output wcu8_pkg::t_q_status o_status,
    output wcu8_pkg::t_rec      o_head
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    wcu8_pkg::t_rec r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == CntW'(DEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n,
        r_count <= CntW'(DEPTH),
        "queue count beyond depth")
    `ASSERT_CLK(a_no_lost_push, i_clk, i_rst_n,
        i_push |-> !o_status.full,
        "request pushed into a full queue")

endmodule

/* rtl/core/wcu8_back.sv */
// ----------------------------------------------------------------------------
// wcu8_back
// Serializer that takes queue records and sends one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcu8_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wcu8_pkg::t_q_status i_q_status,
    input  wcu8_pkg::t_rec      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run,
    output logic                o_encode_error
);

    wcu8_pkg::t_rec r_rec;
    logic           r_busy;
    logic [1:0]     r_idx;
    logic           out_take;
    logic           is_last;

    assign is_last        = (r_idx == r_rec.last_idx);
    assign out_take       = r_busy && !i_out_stall;
    // A new record loads when nothing is held or the final byte leaves now.
    assign o_pop          = i_q_status.valid && (!r_busy || (out_take && is_last));
    assign o_out_valid    = r_busy;
    assign o_out_byte     = r_rec.bytes[r_idx];
    assign o_last_of_run  = is_last;
    assign o_encode_error = r_rec.err;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (out_take) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    `ASSERT_CLK(a_idx_in_run, i_clk, i_rst_n,
        r_busy |-> r_idx <= r_rec.last_idx,
        "byte index ran past the last byte")
    `ASSERT_CLK(a_stall_holds_idx, i_clk, i_rst_n,
        r_busy && i_out_stall |=> r_busy && $stable(r_idx),
        "byte index moved while the output was stalled")

endmodule

/* dv/wide_char_to_utf8_encoder_tb.sv */
// ----------------------------------------------------------------------------
// wide_char_to_utf8_encoder_tb
// Self-checking bench for the wide character to UTF-8 encoder. A table of
// directed requests covers the range edges, surrogate pairs and error cases.
// Random requests follow in several phases with the supplementary enable
// toggled between phases. Every output byte is compared with the directed
// table or with a software encoder keeping its own copy of the surrogate state.
// ----------------------------------------------------------------------------
module wide_char_to_utf8_encoder_tb;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned SETTLE_WAIT  = 20;
    localparam int unsigned NUM_DIRECTED = 27;
    localparam int unsigned NUM_PHASES   = 5;
    localparam int unsigned PHASE_ITEMS  = 47;
    localparam logic [31:0] FirstSupp    = wcu8_pkg::LimBmp + 32'd1;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
        logic       err;
    } t_utf8_out;

    // A row with nbytes of zero is checked against the software encoder only.
    typedef struct {
        logic [31:0]      unit;
        bit               dse;
        int               nbytes;
        logic [0:3][7:0]  bytes;
        bit               err;
    } t_dir_row;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] code_unit;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        encode_error;

    t_utf8_out expected_bytes[$];
    int        error_count  = 0;
    int        quiet_cycles = 0;
    bit        rx_hold_req  = 1'b0;
    bit        quiet_mode   = 1'b0;
    int        burst_left   = 0;

    // Encoder state mirrored by the software model.
    bit         dse_en      = 1'b1;
    bit         sur_pending = 1'b0;
    logic [1:0] sur_bits    = 2'b00;

    t_dir_row dir_rows [NUM_DIRECTED] = '{
        '{32'h0000_0000, 1'b1, 1, 32'h0000_0000, 1'b0},
        '{32'h0000_007F, 1'b1, 1, 32'h7F00_0000, 1'b0},
        '{32'h0000_0080, 1'b1, 2, 32'hC280_0000, 1'b0},
        '{32'h0000_07FF, 1'b1, 2, 32'hDFBF_0000, 1'b0},
        '{32'h0000_0800, 1'b1, 3, 32'hE0A0_8000, 1'b0},
        '{32'h0000_D7FF, 1'b1, 3, 32'hED9F_BF00, 1'b0},
        '{32'h0000_E000, 1'b1, 3, 32'hEE80_8000, 1'b0},
        '{32'h0000_FFFF, 1'b1, 3, 32'hEFBF_BF00, 1'b0},
        '{32'h0001_0000, 1'b1, 4, 32'hF090_8080, 1'b0},
        '{32'h0010_FFFF, 1'b1, 4, 32'hF48F_BFBF, 1'b0},
        '{32'h0011_0000, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'hFFFF_FFFF, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'h0000_DC00, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'h0000_D800, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_DC00, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_DBFF, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_DFFF, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_D912, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_DA34, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_0041, 1'b1, 1, 32'h4100_0000, 1'b0},
        '{32'h0000_DE00, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'h0000_D955, 1'b1, 0, 32'h0000_0000, 1'b0},
        '{32'h0020_0000, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'h0000_DC55, 1'b1, 1, 32'h0000_0000, 1'b1},
        '{32'h0001_0000, 1'b0, 1, 32'h0000_0000, 1'b1},
        '{32'h0000_D800, 1'b0, 0, 32'h0000_0000, 1'b0},
        '{32'h0000_DFFF, 1'b0, 0, 32'h0000_0000, 1'b0}
    };

    wide_char_to_utf8_encoder uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_code_unit    (code_unit),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_last_of_run  (last_of_run),
        .o_encode_error (encode_error)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Works out the bytes one request produces and advances the surrogate
    // state. With record cleared only the state moves.
    function automatic void encode_utf8(input logic [31:0] cu, input bit record);
        logic [7:0] b [4];
        logic [4:0] plane;
        int         n;
        bit         err;
        n   = 0;
        err = 1'b0;
        if (cu <= wcu8_pkg::Lim1Byte) begin
            b[0] = cu[7:0];
            n = 1;
        end else if (cu <= wcu8_pkg::Lim2Byte) begin
            b[0] = wcu8_pkg::Lead2 | {3'b000, cu[10:6]};
            b[1] = wcu8_pkg::Cont  | {2'b00, cu[5:0]};
            n = 2;
        end else if (cu <= wcu8_pkg::LimLowBmp
                     || (cu >= wcu8_pkg::HighBmpLo && cu <= wcu8_pkg::LimBmp)) begin
            b[0] = wcu8_pkg::Lead3 | {4'h0, cu[15:12]};
            b[1] = wcu8_pkg::Cont  | {2'b00, cu[11:6]};
            b[2] = wcu8_pkg::Cont  | {2'b00, cu[5:0]};
            n = 3;
        end else if (cu >= wcu8_pkg::HighSurLo && cu <= wcu8_pkg::HighSurHi) begin
            plane = {1'b0, cu[9:6]} + 5'd1;
            b[0] = wcu8_pkg::Lead4 | {5'b00000, plane[4:2]};
            b[1] = wcu8_pkg::Cont  | {2'b00, plane[1:0], cu[5:2]};
            n = 2;
        end else if (cu >= wcu8_pkg::LowSurLo && cu <= wcu8_pkg::LowSurHi) begin
            if (sur_pending) begin
                b[0] = wcu8_pkg::Cont | {2'b00, sur_bits, cu[9:6]};
                b[1] = wcu8_pkg::Cont | {2'b00, cu[5:0]};
                n = 2;
            end else begin
                err = 1'b1;
            end
        end else if (dse_en && cu >= FirstSupp && cu <= wcu8_pkg::LimUnicode) begin
            b[0] = wcu8_pkg::Lead4 | {5'b00000, cu[20:18]};
            b[1] = wcu8_pkg::Cont  | {2'b00, cu[17:12]};
            b[2] = wcu8_pkg::Cont  | {2'b00, cu[11:6]};
            b[3] = wcu8_pkg::Cont  | {2'b00, cu[5:0]};
            n = 4;
        end else begin
            err = 1'b1;
        end

        // An isolated low surrogate is the one case that leaves the state alone.
        if (cu >= wcu8_pkg::HighSurLo && cu <= wcu8_pkg::HighSurHi) begin
            sur_pending = 1'b1;
            sur_bits    = cu[1:0];
        end else if (!(err && cu >= wcu8_pkg::LowSurLo && cu <= wcu8_pkg::LowSurHi)) begin
            sur_pending = 1'b0;
            sur_bits    = 2'b00;
        end

        if (record) begin
            if (err) begin
                expected_bytes.push_back('{val: 8'h00, last: 1'b1, err: 1'b1});
            end else begin
                for (int k = 0; k < n; k++) begin
                    expected_bytes.push_back('{val: b[k], last: (k == n - 1), err: 1'b0});
                end
            end
        end
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || burst_left > 0) begin
            return 0;
        end else if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    function automatic logic [31:0] pick_edge_unit();
        case ($urandom_range(0, 13))
            0:       return wcu8_pkg::Lim1Byte;
            1:       return wcu8_pkg::Lim1Byte + 32'd1;
            2:       return wcu8_pkg::Lim2Byte;
            3:       return wcu8_pkg::Lim2Byte + 32'd1;
            4:       return wcu8_pkg::LimLowBmp;
            5:       return wcu8_pkg::HighSurLo;
            6:       return wcu8_pkg::HighSurHi;
            7:       return wcu8_pkg::LowSurLo;
            8:       return wcu8_pkg::LowSurHi;
            9:       return wcu8_pkg::HighBmpLo;
            10:      return wcu8_pkg::LimBmp;
            11:      return FirstSupp;
            12:      return wcu8_pkg::LimUnicode;
            default: return wcu8_pkg::LimUnicode + 32'd1;
        endcase
    endfunction

    task automatic sender_idle(input int cycles);
        @(negedge clk);
        in_valid  <= 1'b0;
        code_unit <= $urandom();
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Offers one request after a random gap and waits until it is taken.
    task automatic offer_unit(input logic [31:0] cu, input bit record);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            sender_idle(gap);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        code_unit <= cu;
        do @(posedge clk); while (in_stall);
        encode_utf8(cu, record);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) @(posedge clk);
    endtask

    task automatic write_dse(input bit value);
        sender_idle(1);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        dse_en = value;
    endtask

    // Output side: random stall pattern, with one long hold-off on request.
    initial begin : rx_side
        int r;
        int len;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                out_stall <= 1'b1;
                rx_hold_req = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (quiet_mode) begin
                out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 8);
                end else if (r < 90) begin
                    out_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    len = $urandom_range(5, 30);
                end
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin : byte_check
        t_utf8_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected output byte %02h", out_byte);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.val) begin
                    $error("out_byte: expected %02h, actual %02h", want.val, out_byte);
                    error_count++;
                end
                if (last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
                    error_count++;
                end
                if (encode_error !== want.err) begin
                    $error("encode_error: expected %0b, actual %0b", want.err, encode_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          n;
        int          kind;
        bit          phase_dse;
        bit          hold_sent;
        bit          pause_done;
        logic [31:0] cu;

        hold_sent  = 1'b0;
        pause_done = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        code_unit = 32'h0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].dse != dse_en) begin
                write_dse(dir_rows[i].dse);
            end
            offer_unit(dir_rows[i].unit, dir_rows[i].nbytes == 0);
            for (int k = 0; k < dir_rows[i].nbytes; k++) begin
                expected_bytes.push_back('{val: dir_rows[i].bytes[k],
                                           last: (k == dir_rows[i].nbytes - 1),
                                           err: dir_rows[i].err});
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            phase_dse = (phase % 2 == 0);
            write_dse(phase_dse);
            quiet_mode = (phase == 2);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (phase == 1 && !hold_sent && n >= 10) begin
                    // Long output hold-off while requests keep coming.
                    rx_hold_req = 1'b1;
                    burst_left  = 24;
                    hold_sent   = 1'b1;
                end
                if (phase == 0 && !pause_done && n >= 26) begin
                    sender_idle(1);
                    wait_drained();
                    pause_done = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind >= 40 && kind < 65) begin
                    offer_unit($urandom_range(wcu8_pkg::HighSurLo, wcu8_pkg::HighSurHi), 1'b1);
                    offer_unit($urandom_range(wcu8_pkg::LowSurLo, wcu8_pkg::LowSurHi), 1'b1);
                    n += 2;
                end else begin
                    if (kind < 15) begin
                        cu = $urandom_range(0, wcu8_pkg::Lim1Byte);
                    end else if (kind < 25) begin
                        cu = $urandom_range(wcu8_pkg::Lim1Byte + 1, wcu8_pkg::Lim2Byte);
                    end else if (kind < 40) begin
                        cu = $urandom_range(wcu8_pkg::Lim2Byte + 1, wcu8_pkg::LimBmp);
                    end else if (kind < 75) begin
                        cu = $urandom_range(FirstSupp, wcu8_pkg::LimUnicode);
                    end else if (kind < 80) begin
                        cu = $urandom_range(wcu8_pkg::LowSurLo, wcu8_pkg::LowSurHi);
                    end else if (kind < 85) begin
                        cu = $urandom_range(wcu8_pkg::HighSurLo, wcu8_pkg::HighSurHi);
                    end else if (kind < 95) begin
                        cu = $urandom();
                    end else begin
                        cu = pick_edge_unit();
                    end
                    offer_unit(cu, 1'b1);
                    n++;
                end
            end
        end

        quiet_mode = 1'b0;
        sender_idle(1);
        wait_drained();
        repeat (SETTLE_WAIT) @(negedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wcu8_pkg.sv
rtl/core/wcu8_front.sv
rtl/core/wcu8_fifo.sv
rtl/core/wcu8_back.sv
rtl/core/wide_char_to_utf8_encoder.sv
dv/wide_char_to_utf8_encoder_tb.sv
